[design/ibm_pkg.sv]
// Shared types and codes for the inode bitmap allocator.
// Holds command, status and register index codes, the control state type
// and the per-word scan summary. No dependencies.
`default_nettype none

package ibm_pkg;

    // Command codes
    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_FREE   = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_COUNT  = 3'd3;
    localparam logic [2:0] CMD_SETCNT = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_FULL          = 3'd1;
    localparam logic [2:0] ST_BAD_NUMBER    = 3'd2;
    localparam logic [2:0] ST_BLOCK_RANGE   = 3'd3;
    localparam logic [2:0] ST_ALREADY_CLEAR = 3'd4;
    localparam logic [2:0] ST_RESERVED      = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_INODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_FIRST_INODE = 2'd1;
    localparam logic [1:0] CFG_MAP_BLOCKS  = 2'd2;

    // Control states
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SPARE = 4'b1000
    } t_state;

    // Summary of one bitmap word under a valid-bit mask
    typedef struct packed {
        logic       found;   // some valid bit is clear
        logic [5:0] pos;     // lowest valid clear bit
        logic [6:0] zeros;   // number of valid clear bits
    } t_word_info;

endpackage

`default_nettype wire

[design/ibm_map_ram.sv]
// Bitmap word memory: one write port, one registered read port.
// Uses no package items.
`default_nettype none

module ibm_map_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [63:0]   o_rdata
);

    logic [63:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/ibm_word_eval.sv]
// Evaluates one bitmap word: lowest clear bit and clear-bit count
// within a valid-bit mask. Depends on ibm_pkg.
`default_nettype none

module ibm_word_eval
    import ibm_pkg::*;
(
    input  wire logic [63:0] i_word,
    input  wire logic [63:0] i_mask,
    output      t_word_info  o_info
);

    logic [63:0] zb;
    logic [63:0] lowest;
    logic [5:0]  pos;
    logic [1:0]  l1 [32];
    logic [2:0]  l2 [16];
    logic [3:0]  l3 [8];
    logic [4:0]  l4 [4];
    logic [5:0]  l5 [2];

    // clear bits inside the mask, and the lowest of them isolated
    assign zb     = ~i_word & i_mask;
    assign lowest = zb & (~zb + 64'd1);

    // encode the one-hot lowest clear bit
    always_comb begin
        pos = '0;
        for (int k = 0; k < 6; k++) begin
            for (int b = 0; b < 64; b++) begin
                if (b[k]) begin
                    pos[k] = pos[k] | lowest[b];
                end
            end
        end
    end

    // population count as an adder tree
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            l1[i] = {1'b0, zb[2*i]} + {1'b0, zb[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
    end

    assign o_info.found = |zb;
    assign o_info.pos   = pos;
    assign o_info.zeros = {1'b0, l5[0]} + {1'b0, l5[1]};

endmodule

`default_nettype wire

[design/inode_bitmap_allocator.sv]
// Inode bitmap allocator: control sequencer, configuration and free counter.
// Write word, set counter and rejected requests finish straight from idle; free reads one
// word and rewrites it; allocate and count scan words in turn, up to the last word in range.
// One request at a time; the next is taken at the edge ending the result strobe.
// After reset a clearing pass zeroes every map word with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module inode_bitmap_allocator
    import ibm_pkg::*;
#(
    parameter int MAP_WORDS  = 256,
    parameter int BLOCK_BITS = 8192
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_inode_number,
    input  wire logic [7:0]  i_word_index,
    input  wire logic [63:0] i_data_word,
    output      logic        o_done,
    output      logic [13:0] o_result_inode,
    output      logic [2:0]  o_status,
    output      logic [15:0] o_free_count,
    output      logic [14:0] o_bit_count,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);

    localparam int TOTAL = MAP_WORDS * 64;
    localparam int LW    = $clog2(TOTAL + 1);
    localparam int XW    = (LW > 18) ? LW : 18;
    localparam int AW    = $clog2(MAP_WORDS);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_ra, n_ra;
    logic            r_rdone, n_rdone;
    logic [AW-1:0]   r_last, n_last;
    logic [LW-1:0]   r_limit, n_limit;
    logic [2:0]      r_cmd, n_cmd;
    logic [5:0]      r_bit, n_bit;
    logic [LW-1:0]   r_cnt, n_cnt;
    logic [15:0]     r_free, n_free;
    logic            r_rvld;
    logic [AW-1:0]   r_wa;
    logic            n_done;
    logic [13:0]     n_res;
    logic [2:0]      n_status;
    logic [14:0]     n_bitcnt;

    logic [14:0]     r_inode_count;
    logic [13:0]     r_first_inode;
    logic [1:0]      r_map_blocks;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [63:0]     rd_data;
    logic            we;
    logic [AW-1:0]   wa;
    logic [63:0]     wd;

    logic [XW-1:0]   blk_lim;
    logic [LW-1:0]   alloc_lim, cnt_lim, lim_sel;
    logic [AW-1:0]   last_w;
    logic [XW-1:0]   num_x;
    logic            free_bad, free_blk;
    logic [AW-1:0]   free_wa;
    logic [LW-1:0]   rem;
    logic [63:0]     vmask;
    t_word_info      info;
    logic [AW+5:0]   alloc_idx;
    logic [LW-1:0]   cnt_sum;

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_free_count = r_free;

    // bitmap storage
    ibm_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wa),
        .i_wdata (wd),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // valid bits of the word being scanned
    assign rem   = r_limit - LW'({r_wa, 6'd0});
    assign vmask = (rem >= LW'(64)) ? {64{1'b1}} : ~({64{1'b1}} << rem[5:0]);

    ibm_word_eval u_eval (
        .i_word (rd_data),
        .i_mask (vmask),
        .o_info (info)
    );

    assign alloc_idx = {r_wa, info.pos};
    assign cnt_sum   = r_cnt + LW'(info.zeros);

    // scan limits
    always_comb begin
        case (r_map_blocks)
            2'd0:    blk_lim = '0;
            2'd1:    blk_lim = XW'(BLOCK_BITS);
            2'd2:    blk_lim = XW'(2 * BLOCK_BITS);
            default: blk_lim = XW'(3 * BLOCK_BITS);
        endcase
    end

    assign alloc_lim = (XW'(r_inode_count) < XW'(TOTAL)) ? LW'(r_inode_count) : LW'(TOTAL);
    assign cnt_lim   = (blk_lim < XW'(TOTAL)) ? LW'(blk_lim) : LW'(TOTAL);
    assign lim_sel   = (i_command == CMD_ALLOC) ? alloc_lim : cnt_lim;
    assign last_w    = AW'((lim_sel - LW'(1)) >> 6);

    // free request checks
    assign num_x    = XW'(i_inode_number);
    assign free_bad = (num_x < XW'(r_first_inode)) || (num_x > XW'(r_inode_count));
    assign free_blk = (num_x >= blk_lim) || (num_x >= XW'(TOTAL));
    assign free_wa  = AW'(i_inode_number >> 6);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_ra     = r_ra;
        n_rdone  = r_rdone;
        n_last   = r_last;
        n_limit  = r_limit;
        n_cmd    = r_cmd;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_free   = r_free;
        n_done   = 1'b0;
        n_res    = '0;
        n_status = ST_OK;
        n_bitcnt = '0;
        rd_en    = 1'b0;
        rd_addr  = r_ra;
        we       = 1'b0;
        wa       = r_wa;
        wd       = rd_data;
        case (r_state)
            S_CLEAR: begin
                we   = 1'b1;
                wa   = r_ra;
                wd   = '0;
                n_ra = r_ra + AW'(1);
                if (r_ra == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                    n_ra    = '0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    case (i_command)
                        CMD_ALLOC, CMD_COUNT: begin
                            if (lim_sel == '0) begin
                                n_done   = 1'b1;
                                n_status = (i_command == CMD_ALLOC) ? ST_FULL : ST_OK;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_ra    = AW'(1);
                                n_rdone = (last_w == '0);
                                n_last  = last_w;
                                n_limit = lim_sel;
                                n_cnt   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            if (free_bad) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_NUMBER;
                            end else if (free_blk) begin
                                n_done   = 1'b1;
                                n_status = ST_BLOCK_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = free_wa;
                                n_rdone = 1'b1;
                                n_bit   = i_inode_number[5:0];
                                n_state = S_SCAN;
                            end
                        end
                        CMD_WRITE: begin
                            if (32'(i_word_index) < MAP_WORDS) begin
                                we = 1'b1;
                                wa = AW'(i_word_index);
                                wd = i_data_word;
                            end
                            n_done = 1'b1;
                        end
                        CMD_SETCNT: begin
                            n_free = i_data_word[15:0];
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // examine the word returned by the memory
                if (r_rvld) begin
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (info.found) begin
                                we      = 1'b1;
                                wd      = rd_data | (64'd1 << info.pos);
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                                if (XW'(alloc_idx) < XW'(r_first_inode)) begin
                                    n_status = ST_RESERVED;
                                end else begin
                                    n_res  = 14'(alloc_idx);
                                    n_free = r_free - 16'd1;
                                end
                            end else if (r_wa == r_last) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                                n_state  = S_IDLE;
                            end
                        end
                        CMD_COUNT: begin
                            if (r_wa == r_last) begin
                                n_done   = 1'b1;
                                n_bitcnt = 15'(cnt_sum);
                                n_state  = S_IDLE;
                            end else begin
                                n_cnt = cnt_sum;
                            end
                        end
                        CMD_FREE: begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                            if (!rd_data[r_bit]) begin
                                n_status = ST_ALREADY_CLEAR;
                            end else begin
                                we     = 1'b1;
                                wd     = rd_data & ~(64'd1 << r_bit);
                                n_free = r_free + 16'd1;
                            end
                        end
                        default: begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
                // keep the read pipeline full until the last word
                if (!r_rdone && !n_done) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ra;
                    n_ra    = r_ra + AW'(1);
                    n_rdone = (r_ra == r_last);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ra    <= '0;
            r_rdone <= 1'b1;
            r_rvld  <= 1'b0;
            r_free  <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ra    <= n_ra;
            r_rdone <= n_rdone;
            r_rvld  <= rd_en;
            r_free  <= n_free;
            o_done  <= n_done;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_count <= 15'd16384;
            r_first_inode <= 14'd1;
            r_map_blocks  <= 2'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INODE_COUNT: r_inode_count <= i_cfg_data;
                CFG_FIRST_INODE: r_first_inode <= i_cfg_data[13:0];
                CFG_MAP_BLOCKS:  r_map_blocks  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_limit <= n_limit;
        r_cmd   <= n_cmd;
        r_bit   <= n_bit;
        r_cnt   <= n_cnt;
        if (rd_en) begin
            r_wa <= rd_addr;
        end
        o_result_inode <= n_res;
        o_status       <= n_status;
        o_bit_count    <= n_bitcnt;
    end

    // every accepted request either finishes next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request neither finished nor busy");

    // a result strobe follows a scan cycle or an accepted request
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state == S_SCAN) || $past(start && !busy)))
        else $error("result strobe without a request");

    // read-modify-write only on a word that was actually read
    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && we) |-> r_rvld)
        else $error("map write in scan without read data");

    // the free counter moves only with a result
    a_free_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_free != $past(r_free))) |-> o_done)
        else $error("free counter changed without a result");

endmodule

`default_nettype wire

[verif/inode_bitmap_allocator_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for inode_bitmap_allocator: directed and random requests,
// each result checked against a bitmap mirror kept in the bench itself.
// Depends on ibm_pkg (codes) and the inode_bitmap_allocator RTL.

module inode_bitmap_allocator_test;
    import ibm_pkg::*;

    localparam int MAP_WORDS    = 256;
    localparam int BLOCK_BITS   = 8192;
    localparam int MAP_BITS     = MAP_WORDS * 64;
    localparam int WORD_AW      = $clog2(MAP_WORDS);
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 8;
    // commands 5 to 7 do nothing
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;

    // one expected result
    typedef struct packed {
        logic [13:0] inode;
        logic [2:0]  status;
        logic [15:0] free_count;
        logic [14:0] bit_count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_command;
    logic [15:0] i_inode_number;
    logic [7:0]  i_word_index;
    logic [63:0] i_data_word;
    logic        o_done;
    logic [13:0] o_result_inode;
    logic [2:0]  o_status;
    logic [15:0] o_free_count;
    logic [14:0] o_bit_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [14:0] i_cfg_data;

    // mirror of the block state and registers
    logic [63:0] map_mirror [MAP_WORDS];
    logic [15:0] free_mirror;
    int unsigned inode_count_r;
    int unsigned first_inode_r;
    int unsigned map_blocks_r;

    t_outcome    outcome_q [$];
    int unsigned granted_q [$];
    int          mismatch_cnt = 0;
    bit          sender_steady = 1'b0;

    inode_bitmap_allocator #(
        .MAP_WORDS  (MAP_WORDS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_inode_number (i_inode_number),
        .i_word_index   (i_word_index),
        .i_data_word    (i_data_word),
        .o_done         (o_done),
        .o_result_inode (o_result_inode),
        .o_status       (o_status),
        .o_free_count   (o_free_count),
        .o_bit_count    (o_bit_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic map_bit(input int unsigned n);
        return map_mirror[WORD_AW'(n >> 6)][6'(n)];
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom());
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom());
    endfunction

    // Work out the result of one accepted request and update the mirror
    task automatic predict_request(input logic [2:0] cmd, input logic [15:0] num,
                                   input logic [7:0] widx, input logic [63:0] data);
        t_outcome    res;
        int unsigned limit;
        int unsigned n;
        int unsigned zeros;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_ALLOC: begin
                limit = (inode_count_r < MAP_BITS) ? inode_count_r : MAP_BITS;
                n = 0;
                // skip whole words that are full
                while (n < limit && map_bit(n)) begin
                    if (n % 64 == 0 && (&map_mirror[WORD_AW'(n >> 6)])) n += 64;
                    else n++;
                end
                if (n >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    map_mirror[WORD_AW'(n >> 6)][6'(n)] = 1'b1;
                    if (n < first_inode_r) begin
                        res.status = ST_RESERVED;
                    end else begin
                        res.inode = 14'(n);
                        free_mirror = free_mirror - 16'd1;
                        granted_q.push_back(n);
                    end
                end
            end
            CMD_FREE: begin
                n = 32'(num);
                if (n < first_inode_r || n > inode_count_r) begin
                    res.status = ST_BAD_NUMBER;
                end else if (n / BLOCK_BITS >= map_blocks_r || n >= MAP_BITS) begin
                    res.status = ST_BLOCK_RANGE;
                end else if (!map_bit(n)) begin
                    res.status = ST_ALREADY_CLEAR;
                end else begin
                    map_mirror[WORD_AW'(n >> 6)][6'(n)] = 1'b0;
                    free_mirror = free_mirror + 16'd1;
                end
            end
            CMD_WRITE: begin
                if (32'(widx) < MAP_WORDS) map_mirror[widx] = data;
            end
            CMD_COUNT: begin
                limit = map_blocks_r * BLOCK_BITS;
                if (limit > MAP_BITS) limit = MAP_BITS;
                zeros = 0;
                for (int w = 0; w < limit / 64; w++)
                    zeros += 64 - $countones(map_mirror[WORD_AW'(w)]);
                res.bit_count = 15'(zeros);
            end
            CMD_SETCNT: begin
                free_mirror = data[15:0];
            end
            default: ;
        endcase
        res.free_count = free_mirror;
        outcome_q.push_back(res);
    endtask

    // Drive one request and hold it until the block takes it
    task automatic send_request(input logic [2:0] cmd, input logic [15:0] num,
                                input logic [7:0] widx, input logic [63:0] data);
        @(negedge i_clk);
        start          = 1'b1;
        i_command      = cmd;
        i_inode_number = num;
        i_word_index   = widx;
        i_data_word    = data;
        do @(posedge i_clk); while (busy);
        predict_request(cmd, num, widx, data);
    endtask

    // Random gap between requests
    task automatic maybe_idle();
        int unsigned gap;
        if (!sender_steady && $urandom_range(99) < 30) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Write all three registers once the block has gone quiet
    task automatic write_config(input int unsigned inode_cnt, input int unsigned first_ino,
                                input int unsigned blk_cnt);
        logic [1:0]  idx_list [3];
        logic [14:0] val_list [3];
        idx_list[0] = CFG_INODE_COUNT;
        idx_list[1] = CFG_FIRST_INODE;
        idx_list[2] = CFG_MAP_BLOCKS;
        val_list[0] = 15'(inode_cnt);
        val_list[1] = 15'(first_ino);
        val_list[2] = 15'(blk_cnt);
        @(negedge i_clk);
        start = 1'b0;
        while (outcome_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid = 1'b1;
            i_cfg_index = idx_list[k];
            i_cfg_data  = val_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx_list[k])
                CFG_INODE_COUNT: inode_count_r = 32'(val_list[k]);
                CFG_FIRST_INODE: first_inode_r = 32'(val_list[k][13:0]);
                CFG_MAP_BLOCKS:  map_blocks_r  = 32'(val_list[k][1:0]);
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    // Basic behavior from the reset state: reserved bit 0, counter wrap, free errors
    task automatic test_after_reset();
        send_request(CMD_COUNT, rnd16(), rnd8(), rnd64());
        send_request(CMD_ALLOC, rnd16(), rnd8(), rnd64());
        maybe_idle();
        send_request(CMD_ALLOC, rnd16(), rnd8(), rnd64());
        send_request(CMD_SETCNT, rnd16(), rnd8(), 64'hFFFF_FFFF_FFFF_0000);
        send_request(CMD_ALLOC, rnd16(), rnd8(), rnd64());
        maybe_idle();
        send_request(CMD_SETCNT, rnd16(), rnd8(), 64'h0000_0000_0000_FFFF);
        send_request(CMD_FREE, 16'd2, rnd8(), rnd64());
        send_request(CMD_FREE, 16'd2, rnd8(), rnd64());
        send_request(CMD_FREE, 16'd0, rnd8(), rnd64());
        maybe_idle();
        send_request(CMD_FREE, 16'd16384, rnd8(), rnd64());
        send_request(CMD_FREE, 16'hFFFF, rnd8(), rnd64());
        send_request(CMD_WRITE, rnd16(), 8'd255, '1);
        send_request(CMD_WRITE, rnd16(), 8'd0, '1);
        maybe_idle();
        send_request(CMD_ALLOC, rnd16(), rnd8(), rnd64());
        send_request(CMD_FREE, 16'd16383, rnd8(), rnd64());
        for (int k = 0; k < 3; k++)
            send_request(CMD_FIRST_UNUSED + 3'(k), rnd16(), rnd8(), rnd64());
        send_request(CMD_COUNT, rnd16(), rnd8(), rnd64());
    endtask

    // Register extremes: one block in use, a single inode, a reserved range covering it
    task automatic test_config_extremes();
        write_config(16384, 0, 1);
        send_request(CMD_FREE, 16'd8192, rnd8(), rnd64());
        send_request(CMD_COUNT, rnd16(), rnd8(), rnd64());
        send_request(CMD_FREE, 16'd0, rnd8(), rnd64());
        write_config(1, 16383, 2);
        send_request(CMD_ALLOC, rnd16(), rnd8(), rnd64());
        send_request(CMD_ALLOC, rnd16(), rnd8(), rnd64());
        send_request(CMD_FREE, 16'd0, rnd8(), rnd64());
        write_config(1, 0, 2);
        send_request(CMD_FREE, 16'd1, rnd8(), rnd64());
    endtask

    // One random request, biased toward allocate/free of live numbers
    task automatic random_request();
        int unsigned pick;
        int unsigned sel;
        int unsigned top_word;
        logic [2:0]  cmd;
        logic [15:0] num;
        logic [7:0]  widx;
        logic [63:0] data;
        num  = rnd16();
        widx = rnd8();
        data = rnd64();
        pick = $urandom_range(99);
        if (pick < 38) cmd = CMD_ALLOC;
        else if (pick < 70) cmd = CMD_FREE;
        else if (pick < 82) cmd = CMD_WRITE;
        else if (pick < 87) cmd = CMD_COUNT;
        else if (pick < 93) cmd = CMD_SETCNT;
        else cmd = 3'($urandom_range(CMD_FIRST_UNUSED, 7));

        if (cmd == CMD_FREE) begin
            sel = $urandom_range(99);
            if (sel < 50 && granted_q.size() > 0) begin
                pick = $urandom_range(granted_q.size() - 1);
                num  = 16'(granted_q[pick]);
                granted_q.delete(pick);
            end else if (sel < 85) begin
                num = 16'($urandom_range(inode_count_r + 1));
            end
        end else if (cmd == CMD_WRITE) begin
            top_word = (inode_count_r + 63) / 64;
            if (top_word > MAP_WORDS - 1) top_word = MAP_WORDS - 1;
            if ($urandom_range(99) < 70) widx = 8'($urandom_range(top_word));
            case ($urandom_range(3))
                0: data = '1;
                1: data = '0;
                2: data = ~(64'd1 << $urandom_range(63));
                default: ;
            endcase
        end
        send_request(cmd, num, widx, data);
    endtask

    // Random traffic over several register settings
    task automatic test_random_traffic();
        int unsigned inode_cnt;
        int unsigned first_ino;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(3))
                0: inode_cnt = $urandom_range(1, 64);
                1: inode_cnt = $urandom_range(65, 600);
                2: inode_cnt = $urandom_range(601, 16384);
                default: inode_cnt = 16384;
            endcase
            if (p == 2) inode_cnt = $urandom_range(1, 64);
            first_ino = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(16);
            if (p == 0) write_config(16384, 1, 2);
            else if (p == 1) write_config(16384, 0, 1);
            else write_config(inode_cnt, first_ino, $urandom_range(1, 2));
            // first phase runs with no gaps at all
            sender_steady = (p == 0);
            repeat (RANDOM_ITEMS / PHASES) begin
                random_request();
                maybe_idle();
            end
        end
    endtask

    // Compare each result with the oldest expectation
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got inode %0d status %0d",
                         $time, o_result_inode, o_status);
                mismatch_cnt++;
            end else begin
                want = outcome_q.pop_front();
                check_field("result_inode", 16'(want.inode), 16'(o_result_inode));
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("free_count", want.free_count, o_free_count);
                check_field("bit_count", 16'(want.bit_count), 16'(o_bit_count));
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = CMD_ALLOC;
        i_inode_number = '0;
        i_word_index   = '0;
        i_data_word    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_INODE_COUNT;
        i_cfg_data     = '0;
        foreach (map_mirror[w]) map_mirror[w] = '0;
        free_mirror   = '0;
        inode_count_r = 16384;
        first_inode_r = 1;
        map_blocks_r  = 2;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_after_reset();
        test_config_extremes();
        test_random_traffic();

        @(negedge i_clk);
        start = 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (MAP_WORDS + 8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[inode_bitmap_allocator] OK");
        end else begin
            $display("[inode_bitmap_allocator] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("[inode_bitmap_allocator] ERROR");
        $finish;
    end

endmodule
